[rtl/ehp_pkg.sv]
package ehp_pkg;

    // EtherType and IP protocol codes
    localparam logic [15:0] ETH_VLAN  = 16'h8100;
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    // Byte offsets in the Ethernet header
    localparam int DST_END     = 6;
    localparam int SRC_END     = 12;
    localparam int TYPE_HI     = 12;
    localparam int TYPE_LO     = 13;
    localparam int TAG_HI      = 14;
    localparam int TAG_LO      = 15;
    localparam int INNER_HI    = 16;
    localparam int INNER_LO    = 17;
    localparam int L3_UNTAGGED = 14;
    localparam int L3_TAGGED   = 18;

    // Byte offsets inside the IPv4 header
    localparam int IP_VER_IHL  = 0;
    localparam int IP_TOS      = 1;
    localparam int IP_PROTO    = 9;
    localparam int IP_SRC_LO   = 12;
    localparam int IP_DST_LO   = 16;
    localparam int IP_ADDR_END = 20;
    localparam logic [5:0] MIN_IHL_BYTES = 6'd20;

    // Byte offsets inside the L4 header
    localparam int L4_PORTS_END = 4;
    localparam int TCP_DOFF     = 12;
    localparam int TCP_FLAGS    = 13;
    localparam logic [7:0] UDP_HDR_BYTES = 8'd8;

    // Per-frame parse state
    typedef struct packed {
        logic        vlan;
        logic [5:0]  ihl_bytes;
        logic [5:0]  tcp_hdr_bytes;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] outer_type;
        logic [15:0] tag;
        logic [15:0] inner_type;
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [7:0]  proto;
        logic [7:0]  tos;
        logic [31:0] ports;
        logic [7:0]  flags;
        logic        doff_seen;
    } ehp_state_t;

    // One parse result
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_type;
        logic [11:0] vlan_id;
        logic [31:0] ip_source;
        logic [31:0] ip_dest;
        logic [7:0]  l3_protocol;
        logic [7:0]  type_of_service;
        logic [31:0] l4_ports;
        logic [5:0]  tcp_flag_bits;
        logic [7:0]  payload_start;
        logic        is_ipv4;
    } ehp_result_t;

endpackage

[rtl/ehp_if.sv]
interface ehp_in_if;
    import ehp_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] pkt_byte;
    logic       last_byte;

    modport source (output valid, output pkt_byte, output last_byte, input ready);
    modport sink   (input valid, input pkt_byte, input last_byte, output ready);
endinterface

interface ehp_out_if;
    import ehp_pkg::*;

    logic        valid;
    logic        ready;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [11:0] vlan_id;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [7:0]  l3_protocol;
    logic [7:0]  type_of_service;
    logic [31:0] l4_ports;
    logic [5:0]  tcp_flag_bits;
    logic [7:0]  payload_start;
    logic        is_ipv4;

    modport source (
        output valid, output dst_mac, output src_mac, output ether_type, output vlan_id,
        output ip_source, output ip_dest, output l3_protocol, output type_of_service,
        output l4_ports, output tcp_flag_bits, output payload_start, output is_ipv4,
        input ready
    );
    modport sink (
        input valid, input dst_mac, input src_mac, input ether_type, input vlan_id,
        input ip_source, input ip_dest, input l3_protocol, input type_of_service,
        input l4_ports, input tcp_flag_bits, input payload_start, input is_ipv4,
        output ready
    );
endinterface

[rtl/ethernet_ipv4_l4_header_parser.sv]
// Channel  Role    Carries
// -------  ------  ------------------------------------------------------
// frame    sink    one frame byte per item, last_byte closes the frame
// hdr      source  one parsed header summary per frame
//
// One byte per cycle sustained while the hdr channel takes summaries; a summary
// is valid once the last byte has passed the input register and the result
// register. Each byte passes an input register, then position compare and capture into the parse state.
// Reset clears the byte position and all captured fields.
// A stalled hdr channel holds the last byte in the input register, and the frame channel stalls behind it.
module ethernet_ipv4_l4_header_parser #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic     clk,
    input  logic     rst_n,
    ehp_in_if.sink   frame,
    ehp_out_if.source hdr
);
    import ehp_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       advance;
    logic       slot_free;
    logic       take;
    ehp_state_t cap;

    // Advance the held byte unless its result has nowhere to go
    assign advance       = s1_valid_reg && (!s1_last_reg || slot_free);
    assign frame.ready   = !s1_valid_reg || advance;
    assign take          = frame.valid && frame.ready;
    assign s1_valid_next = take || (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_byte_reg <= frame.pkt_byte;
            s1_last_reg <= frame.last_byte;
        end
    end

    ehp_capture #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .pkt_byte  (s1_byte_reg),
        .last_byte (s1_last_reg),
        .cap       (cap)
    );

    ehp_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && s1_last_reg),
        .cap       (cap),
        .slot_free (slot_free),
        .hdr       (hdr)
    );
endmodule

[rtl/ehp_capture.sv]
module ehp_capture #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          pkt_byte,
    input  logic                last_byte,
    output ehp_pkg::ehp_state_t cap
);
    import ehp_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    ehp_state_t       st_reg;
    ehp_state_t       st_next;
    logic [15:0]      cur_type;
    logic [POS_W-1:0] l3_pos;
    logic [POS_W-1:0] k;
    logic [POS_W-1:0] j;
    logic [POS_W-1:0] ihl_pos;
    logic             l4_ok;
    logic             is_tcp;

    assign cur_type = st_reg.vlan ? st_reg.inner_type : st_reg.outer_type;
    assign l3_pos   = st_reg.vlan ? POS_W'(L3_TAGGED) : POS_W'(L3_UNTAGGED);
    assign k        = pos_reg - l3_pos;
    assign ihl_pos  = POS_W'(st_reg.ihl_bytes);
    assign j        = k - ihl_pos;
    assign is_tcp   = st_reg.proto == PROTO_TCP;
    assign l4_ok    = (st_reg.ihl_bytes >= MIN_IHL_BYTES)
                      && (is_tcp || st_reg.proto == PROTO_UDP);

    // Capture the current byte at its header offset
    always_comb
    begin
        cap      = st_reg;
        pos_next = pos_reg;
        if (advance && pos_reg < POS_MAX)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg < POS_W'(DST_END))
            begin
                cap.dst_mac = {st_reg.dst_mac[39:0], pkt_byte};
            end
            else if (pos_reg < POS_W'(SRC_END))
            begin
                cap.src_mac = {st_reg.src_mac[39:0], pkt_byte};
            end
            else if (pos_reg == POS_W'(TYPE_HI))
            begin
                cap.outer_type[15:8] = pkt_byte;
            end
            else if (pos_reg == POS_W'(TYPE_LO))
            begin
                cap.outer_type[7:0] = pkt_byte;
                cap.vlan = {st_reg.outer_type[15:8], pkt_byte} == ETH_VLAN;
            end
            else if (st_reg.vlan && pos_reg < POS_W'(L3_TAGGED))
            begin
                if (pos_reg == POS_W'(TAG_HI))
                    cap.tag[15:8] = pkt_byte;
                else if (pos_reg == POS_W'(TAG_LO))
                    cap.tag[7:0] = pkt_byte;
                else if (pos_reg == POS_W'(INNER_HI))
                    cap.inner_type[15:8] = pkt_byte;
                else
                    cap.inner_type[7:0] = pkt_byte;
            end
            else if (cur_type == ETH_IPV4 && pos_reg >= l3_pos)
            begin
                // IPv4 header fields
                if (k == POS_W'(IP_VER_IHL))
                    cap.ihl_bytes = {pkt_byte[3:0], 2'b00};
                else if (k == POS_W'(IP_TOS))
                    cap.tos = pkt_byte;
                else if (k == POS_W'(IP_PROTO))
                    cap.proto = pkt_byte;
                else if (k >= POS_W'(IP_SRC_LO) && k < POS_W'(IP_DST_LO))
                    cap.ip_src[8*(3-k[1:0]) +: 8] = pkt_byte;
                else if (k >= POS_W'(IP_DST_LO) && k < POS_W'(IP_ADDR_END))
                    cap.ip_dst[8*(3-k[1:0]) +: 8] = pkt_byte;

                // L4 header fields
                if (l4_ok && k >= ihl_pos)
                begin
                    if (j < POS_W'(L4_PORTS_END))
                    begin
                        cap.ports[8*(3-j[1:0]) +: 8] = pkt_byte;
                    end
                    else if (is_tcp && j == POS_W'(TCP_DOFF))
                    begin
                        cap.tcp_hdr_bytes = {pkt_byte[7:4], 2'b00};
                        cap.doff_seen     = 1'b1;
                    end
                    else if (is_tcp && j == POS_W'(TCP_FLAGS))
                    begin
                        cap.flags = pkt_byte;
                    end
                end
            end
        end
        // Restart the position after the last byte of a frame
        if (advance && last_byte)
            pos_next = '0;
    end

    // Clear all state after the last byte of a frame
    always_comb
    begin
        st_next = cap;
        if (advance && last_byte)
            st_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            st_reg  <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            st_reg  <= st_next;
        end
    end
endmodule

[rtl/ehp_result.sv]
module ehp_result (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ehp_pkg::ehp_state_t cap,
    output logic                slot_free,
    ehp_out_if.source           hdr
);
    import ehp_pkg::*;

    ehp_result_t res_next;
    ehp_result_t res_reg;
    logic        valid_reg;
    logic        valid_next;
    logic [15:0] fin_type;
    logic        ipv4;
    logic        l4;
    logic        tcp;
    logic [7:0]  l3_base;

    assign fin_type = cap.vlan ? cap.inner_type : cap.outer_type;
    assign ipv4     = fin_type == ETH_IPV4;
    assign l4       = ipv4 && cap.ihl_bytes >= MIN_IHL_BYTES
                      && (cap.proto == PROTO_TCP || cap.proto == PROTO_UDP);
    assign tcp      = l4 && cap.proto == PROTO_TCP;
    assign l3_base  = (cap.vlan ? 8'(L3_TAGGED) : 8'(L3_UNTAGGED)) + 8'(cap.ihl_bytes);

    // Format the frame summary
    always_comb
    begin
        res_next                 = '0;
        res_next.dst_mac         = cap.dst_mac;
        res_next.src_mac         = cap.src_mac;
        res_next.ether_type      = fin_type;
        res_next.vlan_id         = cap.vlan ? cap.tag[11:0] : 12'd0;
        res_next.ip_source       = cap.ip_src;
        res_next.ip_dest         = cap.ip_dst;
        res_next.l3_protocol     = cap.proto;
        res_next.type_of_service = cap.tos;
        res_next.l4_ports        = l4 ? cap.ports : 32'd0;
        res_next.tcp_flag_bits   = tcp ? cap.flags[5:0] : 6'd0;
        res_next.is_ipv4         = ipv4;
        if (l4 && cap.proto == PROTO_UDP)
            res_next.payload_start = l3_base + UDP_HDR_BYTES;
        if (tcp && cap.doff_seen)
            res_next.payload_start = l3_base + 8'(cap.tcp_hdr_bytes);
    end

    // Hold the result until taken
    assign slot_free  = !valid_reg || hdr.ready;
    assign valid_next = load || (valid_reg && !hdr.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign hdr.valid           = valid_reg;
    assign hdr.dst_mac         = res_reg.dst_mac;
    assign hdr.src_mac         = res_reg.src_mac;
    assign hdr.ether_type      = res_reg.ether_type;
    assign hdr.vlan_id         = res_reg.vlan_id;
    assign hdr.ip_source       = res_reg.ip_source;
    assign hdr.ip_dest         = res_reg.ip_dest;
    assign hdr.l3_protocol     = res_reg.l3_protocol;
    assign hdr.type_of_service = res_reg.type_of_service;
    assign hdr.l4_ports        = res_reg.l4_ports;
    assign hdr.tcp_flag_bits   = res_reg.tcp_flag_bits;
    assign hdr.payload_start   = res_reg.payload_start;
    assign hdr.is_ipv4         = res_reg.is_ipv4;
endmodule

[tb/sv/ethernet_ipv4_l4_header_parser_tb.sv]
module ethernet_ipv4_l4_header_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ehp_pkg::*;

    localparam int MAX_FRAME_BYTES = 200;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int TAIL_CYCLES     = 8;
    localparam int RANDOM_BYTES    = 400;
    localparam int RANDOM_FRAMES   = 4;
    localparam int FILL_RANDOM     = -1;

    // One frame to build: header layout plus filler for every other byte
    typedef struct {
        bit          raw;
        int          fill;
        bit          has_vlan;
        logic [15:0] tag;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [3:0]  doff;
        int unsigned len;
    } frame_plan_t;

    typedef struct {
        frame_plan_t plan;
        bit          has_gold;
        ehp_result_t gold;
    } directed_row_t;

    logic clk;
    logic rst_n;

    ehp_in_if  frame_if ();
    ehp_out_if hdr_if ();

    ethernet_ipv4_l4_header_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame_if),
        .hdr   (hdr_if)
    );

    // Parser shadow state
    ehp_state_t  parse_st;
    int unsigned byte_pos;

    ehp_result_t   hdr_expected_q[$];
    logic [7:0]    frame_q[$];
    directed_row_t directed_rows[$];

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned bytes_sent;
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    ehp_result_t want;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Header prediction
    // ------------------------------------------------------------------
    function automatic logic [15:0] frame_ether_type();
        return parse_st.vlan ? parse_st.inner_type : parse_st.outer_type;
    endfunction

    function automatic bit l4_active();
        return parse_st.ihl_bytes >= MIN_IHL_BYTES &&
               (parse_st.proto == PROTO_TCP || parse_st.proto == PROTO_UDP);
    endfunction

    // Capture one byte at position p into the shadow state
    function automatic void capture_byte(int unsigned p, logic [7:0] b);
        int unsigned l3;
        int unsigned k;
        int unsigned j;
        if (p < DST_END)
            parse_st.dst_mac = {parse_st.dst_mac[39:0], b};
        else if (p < SRC_END)
            parse_st.src_mac = {parse_st.src_mac[39:0], b};
        else if (p == TYPE_HI)
            parse_st.outer_type[15:8] = b;
        else if (p == TYPE_LO)
        begin
            parse_st.outer_type[7:0] = b;
            parse_st.vlan = ({parse_st.outer_type[15:8], b} == ETH_VLAN);
        end
        else if (parse_st.vlan && p <= INNER_LO)
        begin
            if (p == TAG_HI)
                parse_st.tag[15:8] = b;
            else if (p == TAG_LO)
                parse_st.tag[7:0] = b;
            else if (p == INNER_HI)
                parse_st.inner_type[15:8] = b;
            else
                parse_st.inner_type[7:0] = b;
        end
        else if (frame_ether_type() == ETH_IPV4)
        begin
            l3 = parse_st.vlan ? L3_TAGGED : L3_UNTAGGED;
            if (p >= l3)
            begin
                k = p - l3;
                if (k == IP_VER_IHL)
                    parse_st.ihl_bytes = {b[3:0], 2'b00};
                else if (k == IP_TOS)
                    parse_st.tos = b;
                else if (k == IP_PROTO)
                    parse_st.proto = b;
                else if (k >= IP_SRC_LO && k < IP_DST_LO)
                    parse_st.ip_src[8 * (IP_DST_LO - 1 - k) +: 8] = b;
                else if (k >= IP_DST_LO && k < IP_ADDR_END)
                    parse_st.ip_dst[8 * (IP_ADDR_END - 1 - k) +: 8] = b;
                // L4 header follows the IP options
                if (l4_active() && k >= parse_st.ihl_bytes)
                begin
                    j = k - parse_st.ihl_bytes;
                    if (j < L4_PORTS_END)
                        parse_st.ports[8 * (L4_PORTS_END - 1 - j) +: 8] = b;
                    else if (parse_st.proto == PROTO_TCP && j == TCP_DOFF)
                    begin
                        parse_st.tcp_hdr_bytes = {b[7:4], 2'b00};
                        parse_st.doff_seen     = 1'b1;
                    end
                    else if (parse_st.proto == PROTO_TCP && j == TCP_FLAGS)
                        parse_st.flags = b;
                end
            end
        end
    endfunction

    // Advance the shadow parser by one byte; returns 1 with the summary on the last byte
    function automatic bit advance_parser(input logic [7:0] b, input logic last,
                                          output ehp_result_t res);
        logic [15:0] eth;
        int unsigned l3;
        bit          l4_ok;
        bit          tcp_ok;
        res = '0;
        if (byte_pos < MAX_FRAME_BYTES)
        begin
            capture_byte(byte_pos, b);
            byte_pos++;
        end
        if (!last)
            return 1'b0;

        eth    = frame_ether_type();
        l3     = parse_st.vlan ? L3_TAGGED : L3_UNTAGGED;
        l4_ok  = (eth == ETH_IPV4) && l4_active();
        tcp_ok = l4_ok && parse_st.proto == PROTO_TCP;

        res.dst_mac         = parse_st.dst_mac;
        res.src_mac         = parse_st.src_mac;
        res.ether_type      = eth;
        res.vlan_id         = parse_st.vlan ? parse_st.tag[11:0] : 12'd0;
        res.ip_source       = parse_st.ip_src;
        res.ip_dest         = parse_st.ip_dst;
        res.l3_protocol     = parse_st.proto;
        res.type_of_service = parse_st.tos;
        res.l4_ports        = l4_ok ? parse_st.ports : 32'd0;
        res.tcp_flag_bits   = tcp_ok ? parse_st.flags[5:0] : 6'd0;
        res.is_ipv4         = (eth == ETH_IPV4);
        if (l4_ok && parse_st.proto == PROTO_UDP)
            res.payload_start = 8'(l3 + parse_st.ihl_bytes + UDP_HDR_BYTES);
        if (tcp_ok && parse_st.doff_seen)
            res.payload_start = 8'(l3 + parse_st.ihl_bytes + parse_st.tcp_hdr_bytes);

        // Clear for the next frame
        parse_st = '0;
        byte_pos = 0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Frame construction
    // ------------------------------------------------------------------
    function automatic frame_plan_t mk_plan(bit raw, int fill, bit has_vlan, logic [15:0] tag,
                                            logic [15:0] etype, logic [3:0] ihl,
                                            logic [7:0] proto, logic [3:0] doff,
                                            int unsigned len);
        frame_plan_t fp;
        fp.raw      = raw;
        fp.fill     = fill;
        fp.has_vlan = has_vlan;
        fp.tag      = tag;
        fp.etype    = etype;
        fp.ihl      = ihl;
        fp.proto    = proto;
        fp.doff     = doff;
        fp.len      = len;
        return fp;
    endfunction

    function automatic ehp_result_t header_only(logic [47:0] dst, logic [47:0] src,
                                                logic [15:0] eth);
        ehp_result_t res;
        res            = '0;
        res.dst_mac    = dst;
        res.src_mac    = src;
        res.ether_type = eth;
        res.is_ipv4    = (eth == ETH_IPV4);
        return res;
    endfunction

    function automatic void add_row(frame_plan_t fp, bit has_gold, ehp_result_t gold);
        directed_row_t row;
        row.plan     = fp;
        row.has_gold = has_gold;
        row.gold     = gold;
        directed_rows.push_back(row);
    endfunction

    function automatic void set_byte(int unsigned idx, logic [7:0] v);
        if (idx < frame_q.size())
            frame_q[idx] = v;
    endfunction

    // Fill frame_q from a plan; len of zero means the whole header plus 0 to 12 payload bytes
    function automatic void build_frame(frame_plan_t fp);
        int unsigned l3;
        int unsigned l4;
        int unsigned l4_len;
        int unsigned full_len;
        frame_q.delete();
        l3 = fp.has_vlan ? L3_TAGGED : L3_UNTAGGED;
        l4 = (fp.ihl < 5) ? l3 + IP_ADDR_END : l3 + 4 * fp.ihl;
        if (fp.proto == PROTO_UDP)
            l4_len = UDP_HDR_BYTES;
        else if (fp.proto == PROTO_TCP)
            l4_len = (4 * fp.doff > TCP_FLAGS) ? 4 * fp.doff : TCP_FLAGS + 1;
        else
            l4_len = UDP_HDR_BYTES;
        full_len = (fp.len != 0) ? fp.len : l4 + l4_len + $urandom_range(0, 12);
        repeat (full_len)
            frame_q.push_back(fp.fill < 0 ? 8'($urandom) : 8'(fp.fill));
        if (fp.raw)
            return;

        if (fp.has_vlan)
        begin
            set_byte(TYPE_HI, ETH_VLAN[15:8]);
            set_byte(TYPE_LO, ETH_VLAN[7:0]);
            set_byte(TAG_HI, fp.tag[15:8]);
            set_byte(TAG_LO, fp.tag[7:0]);
            set_byte(INNER_HI, fp.etype[15:8]);
            set_byte(INNER_LO, fp.etype[7:0]);
        end
        else
        begin
            set_byte(TYPE_HI, fp.etype[15:8]);
            set_byte(TYPE_LO, fp.etype[7:0]);
        end
        set_byte(l3 + IP_VER_IHL, {4'($urandom), fp.ihl});
        set_byte(l3 + IP_PROTO, fp.proto);
        if (fp.ihl >= 5)
            set_byte(l4 + TCP_DOFF, {fp.doff, 4'($urandom)});
    endfunction

    // Mostly well-formed IPv4 TCP/UDP frames, with broken and foreign ones mixed in
    function automatic frame_plan_t random_plan();
        frame_plan_t fp;
        int unsigned pick;
        fp.raw      = ($urandom_range(0, 19) == 0);
        fp.fill     = FILL_RANDOM;
        fp.has_vlan = ($urandom_range(0, 2) == 0);
        fp.tag      = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 85)
            fp.etype = ETH_IPV4;
        else if (pick < 90)
            fp.etype = ETH_VLAN;
        else
            fp.etype = 16'($urandom);
        fp.ihl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 4))
                                             : 4'($urandom_range(5, 15));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            fp.proto = PROTO_TCP;
        else if (pick < 80)
            fp.proto = PROTO_UDP;
        else
            fp.proto = 8'($urandom);
        fp.doff = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 4))
                                              : 4'($urandom_range(5, 15));
        if (fp.raw || $urandom_range(0, 4) == 0)
            fp.len = $urandom_range(1, 80);
        else
            fp.len = 0;
        return fp;
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 50;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Frame byte driver
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        @(negedge clk);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            gap = $urandom_range(1, 9);
            frame_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_if.valid     <= 1'b1;
        frame_if.pkt_byte  <= b;
        frame_if.last_byte <= last;
        do
            @(posedge clk);
        while (frame_if.ready !== 1'b1);
    endtask

    task automatic send_frame(input bit has_gold, input ehp_result_t gold);
        ehp_result_t predicted;
        bit          last;
        foreach (frame_q[i])
        begin
            last = (i == frame_q.size() - 1);
            send_byte(frame_q[i], last);
            if (advance_parser(frame_q[i], last, predicted))
                hdr_expected_q.push_back(has_gold ? gold : predicted);
            bytes_sent++;
        end
    endtask

    // Hold off the source until every summary is back, then let the pipe settle
    task automatic drain_headers();
        @(negedge clk);
        frame_if.valid <= 1'b0;
        while (hdr_expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic shuffle_idle();
        src_idle_pct = pick_idle_pct();
        snk_idle_pct = pick_idle_pct();
    endtask

    // ------------------------------------------------------------------
    // Summary sink: random stall bursts
    // ------------------------------------------------------------------
    initial
    begin
        hdr_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < snk_idle_pct)
            begin
                hdr_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            hdr_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Summary checker
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && hdr_if.valid && hdr_if.ready)
        begin
            if (hdr_expected_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: header summary with none expected: expected nothing, actual %h",
                         $time, hdr_if.dst_mac);
            end
            else
            begin
                want = hdr_expected_q.pop_front();
                check_field("dst_mac", want.dst_mac, hdr_if.dst_mac);
                check_field("src_mac", want.src_mac, hdr_if.src_mac);
                check_field("ether_type", want.ether_type, hdr_if.ether_type);
                check_field("vlan_id", want.vlan_id, hdr_if.vlan_id);
                check_field("ip_source", want.ip_source, hdr_if.ip_source);
                check_field("ip_dest", want.ip_dest, hdr_if.ip_dest);
                check_field("l3_protocol", want.l3_protocol, hdr_if.l3_protocol);
                check_field("type_of_service", want.type_of_service, hdr_if.type_of_service);
                check_field("l4_ports", want.l4_ports, hdr_if.l4_ports);
                check_field("tcp_flag_bits", want.tcp_flag_bits, hdr_if.tcp_flag_bits);
                check_field("payload_start", want.payload_start, hdr_if.payload_start);
                check_field("is_ipv4", want.is_ipv4, hdr_if.is_ipv4);
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (frame_if.valid && frame_if.ready) || (hdr_if.valid && hdr_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_CYCLES)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        ehp_result_t none;
        int unsigned random_start;
        int unsigned random_frames;

        none               = '0;
        rst_n              = 1'b0;
        frame_if.valid     = 1'b0;
        frame_if.pkt_byte  = 8'd0;
        frame_if.last_byte = 1'b0;
        parse_st           = '0;
        byte_pos           = 0;
        src_idle_pct       = 0;
        snk_idle_pct       = 0;
        bytes_sent         = 0;
        mismatch_count     = 0;

        // Raw frames with summaries known by inspection
        add_row(mk_plan(1, 8'hFF, 0, 0, 0, 0, 0, 0, 1), 1,
                header_only(48'hFF, 48'h0, 16'h0));
        add_row(mk_plan(1, 8'h00, 0, 0, 0, 0, 0, 0, 1), 1,
                header_only(48'h0, 48'h0, 16'h0));
        add_row(mk_plan(1, 8'hFF, 0, 0, 0, 0, 0, 0, 14), 1,
                header_only({48{1'b1}}, {48{1'b1}}, 16'hFFFF));
        add_row(mk_plan(1, 8'h00, 0, 0, 0, 0, 0, 0, 14), 1,
                header_only(48'h0, 48'h0, 16'h0));
        // Well-formed TCP and UDP, tagged and untagged, IHL and data offset extremes
        add_row(mk_plan(0, FILL_RANDOM, 0, 0, ETH_IPV4, 5, PROTO_TCP, 5, 0), 0, none);
        add_row(mk_plan(0, FILL_RANDOM, 0, 0, ETH_IPV4, 15, PROTO_UDP, 0, 0), 0, none);
        add_row(mk_plan(0, FILL_RANDOM, 1, 16'hFFFF, ETH_IPV4, 15, PROTO_TCP, 15, 0), 0, none);
        add_row(mk_plan(0, FILL_RANDOM, 1, 16'h0000, ETH_IPV4, 5, PROTO_UDP, 0, 0), 0, none);
        add_row(mk_plan(0, FILL_RANDOM, 0, 0, ETH_IPV4, 6, PROTO_TCP, 0, 0), 0, none);
        // IHL below the minimum: no L4 fields
        add_row(mk_plan(0, FILL_RANDOM, 0, 0, ETH_IPV4, 4, PROTO_TCP, 5, 0), 0, none);
        add_row(mk_plan(0, FILL_RANDOM, 1, 16'h0123, ETH_IPV4, 0, PROTO_UDP, 0, 0), 0, none);
        // Not IPv4, other protocol, nested tag
        add_row(mk_plan(0, FILL_RANDOM, 0, 0, 16'h86DD, 5, PROTO_TCP, 5, 0), 0, none);
        add_row(mk_plan(0, FILL_RANDOM, 0, 0, ETH_IPV4, 5, 8'd1, 5, 0), 0, none);
        add_row(mk_plan(0, FILL_RANDOM, 1, 16'h0FFF, ETH_VLAN, 5, PROTO_TCP, 5, 0), 0, none);
        // Short frames: inner type missing, data offset missing, UDP ending at protocol
        add_row(mk_plan(0, FILL_RANDOM, 1, 16'hF00F, ETH_IPV4, 5, PROTO_TCP, 5, 16), 0, none);
        add_row(mk_plan(0, FILL_RANDOM, 0, 0, ETH_IPV4, 5, PROTO_TCP, 5, 46), 0, none);
        add_row(mk_plan(0, FILL_RANDOM, 0, 0, ETH_IPV4, 5, PROTO_UDP, 0, 24), 0, none);
        add_row(mk_plan(0, FILL_RANDOM, 0, 0, ETH_IPV4, 5, PROTO_TCP, 15, 48), 0, none);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames
        foreach (directed_rows[r])
        begin
            shuffle_idle();
            build_frame(directed_rows[r].plan);
            send_frame(directed_rows[r].has_gold, directed_rows[r].gold);
        end
        drain_headers();

        // Overlong frame: position saturates, trailing bytes are not captured
        src_idle_pct = 2;
        snk_idle_pct = pick_idle_pct();
        build_frame(mk_plan(0, FILL_RANDOM, 1, 16'($urandom), ETH_IPV4, 5, PROTO_TCP, 5,
                            MAX_FRAME_BYTES + 6));
        send_frame(1'b0, none);
        drain_headers();

        // Random frames
        random_start  = bytes_sent;
        random_frames = 0;
        while (bytes_sent - random_start < RANDOM_BYTES || random_frames < RANDOM_FRAMES)
        begin
            shuffle_idle();
            build_frame(random_plan());
            send_frame(1'b0, none);
            random_frames++;
        end

        // Closing stretch at full rate on both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (4)
        begin
            build_frame(random_plan());
            send_frame(1'b0, none);
        end
        drain_headers();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/ehp_pkg.sv
rtl/ehp_if.sv
rtl/ehp_capture.sv
rtl/ehp_result.sv
rtl/ethernet_ipv4_l4_header_parser.sv
tb/sv/ethernet_ipv4_l4_header_parser_tb.sv
